// File: design/sha_pkg.sv
package sha_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COMP,
    ST_PAD,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic        load_iv;
    logic        push;
    logic [63:0] push_word;
    logic        start;
    logic        clr_count;
    logic [3:0]  add_bytes;
  } cmd_t;

  typedef struct packed {
    logic       busy;
    logic [3:0] wpos;
    logic [63:0] byte_count;
  } stat_t;

  localparam logic [63:0] IV512 [8] = '{
    64'h6A09E667F3BCC908, 64'hBB67AE8584CAA73B, 64'h3C6EF372FE94F82B, 64'hA54FF53A5F1D36F1,
    64'h510E527FADE682D1, 64'h9B05688C2B3E6C1F, 64'h1F83D9ABFB41BD6B, 64'h5BE0CD19137E2179};

  localparam logic [63:0] IV384 [8] = '{
    64'hCBBB9D5DC1059ED8, 64'h629A292A367CD507, 64'h9159015A3070DD17, 64'h152FECD8F70E5939,
    64'h67332667FFC00B31, 64'h8EB44A8768581511, 64'hDB0C2E0D64F98FA7, 64'h47B5481DBEFA4FA4};

  localparam logic [63:0] RC [80] = '{
    64'h428A2F98D728AE22, 64'h7137449123EF65CD, 64'hB5C0FBCFEC4D3B2F, 64'hE9B5DBA58189DBBC,
    64'h3956C25BF348B538, 64'h59F111F1B605D019, 64'h923F82A4AF194F9B, 64'hAB1C5ED5DA6D8118,
    64'hD807AA98A3030242, 64'h12835B0145706FBE, 64'h243185BE4EE4B28C, 64'h550C7DC3D5FFB4E2,
    64'h72BE5D74F27B896F, 64'h80DEB1FE3B1696B1, 64'h9BDC06A725C71235, 64'hC19BF174CF692694,
    64'hE49B69C19EF14AD2, 64'hEFBE4786384F25E3, 64'h0FC19DC68B8CD5B5, 64'h240CA1CC77AC9C65,
    64'h2DE92C6F592B0275, 64'h4A7484AA6EA6E483, 64'h5CB0A9DCBD41FBD4, 64'h76F988DA831153B5,
    64'h983E5152EE66DFAB, 64'hA831C66D2DB43210, 64'hB00327C898FB213F, 64'hBF597FC7BEEF0EE4,
    64'hC6E00BF33DA88FC2, 64'hD5A79147930AA725, 64'h06CA6351E003826F, 64'h142929670A0E6E70,
    64'h27B70A8546D22FFC, 64'h2E1B21385C26C926, 64'h4D2C6DFC5AC42AED, 64'h53380D139D95B3DF,
    64'h650A73548BAF63DE, 64'h766A0ABB3C77B2A8, 64'h81C2C92E47EDAEE6, 64'h92722C851482353B,
    64'hA2BFE8A14CF10364, 64'hA81A664BBC423001, 64'hC24B8B70D0F89791, 64'hC76C51A30654BE30,
    64'hD192E819D6EF5218, 64'hD69906245565A910, 64'hF40E35855771202A, 64'h106AA07032BBD1B8,
    64'h19A4C116B8D2D0C8, 64'h1E376C085141AB53, 64'h2748774CDF8EEB99, 64'h34B0BCB5E19B48A8,
    64'h391C0CB3C5C95A63, 64'h4ED8AA4AE3418ACB, 64'h5B9CCA4F7763E373, 64'h682E6FF3D6B2B8A3,
    64'h748F82EE5DEFB2FC, 64'h78A5636F43172F60, 64'h84C87814A1F0AB72, 64'h8CC702081A6439EC,
    64'h90BEFFFA23631E28, 64'hA4506CEBDE82BDE9, 64'hBEF9A3F7B2C67915, 64'hC67178F2E372532B,
    64'hCA273ECEEA26619C, 64'hD186B8C721C0C207, 64'hEADA7DD6CDE0EB1E, 64'hF57D4F7FEE6ED178,
    64'h06F067AA72176FBA, 64'h0A637DC5A2C898A6, 64'h113F9804BEF90DAE, 64'h1B710B35131C471B,
    64'h28DB77F523047D84, 64'h32CAAB7B40C72493, 64'h3C9EBE0A15C9BEBC, 64'h431D67C49C100D4C,
    64'h4CC5D4BECB3E42B6, 64'h597F299CFC657E2A, 64'h5FCB6FAB3AD6FAEC, 64'h6C44198C4A475817};

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam int unsigned LEN_WORD = 14;

endpackage

// File: design/sha_if.sv
interface sha_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] message_word;
  logic [3:0]  valid_bytes;
  logic        last_word;
  modport source (output valid, message_word, valid_bytes, last_word, input ready);
  modport sink (input valid, message_word, valid_bytes, last_word, output ready);
endinterface

interface sha_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_word;
  logic [2:0]  word_index;
  logic        digest_last;
  modport source (output valid, digest_word, word_index, digest_last, input ready);
  modport sink (input valid, digest_word, word_index, digest_last, output ready);
endinterface

// File: design/sha_datapath.sv
module sha_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              mode_i,
  input  sha_pkg::cmd_t     cmd_i,
  input  logic [2:0]        rd_idx_i,
  output sha_pkg::stat_t    stat_o,
  output logic [63:0]       chain_word_o
);

  logic [63:0] chain_q [8];
  logic [63:0] v_q [8];
  logic [63:0] w_q [16];
  logic [63:0] buf_q [16];
  logic [63:0] cnt_q;
  logic [3:0]  wpos_q;
  logic        busy_q;
  logic [6:0]  rnd_q;
  logic [6:0]  rnd_l;

  logic [63:0] w2, w15, s0, s1, wn, wcur, t1, t2, e, a;

  function automatic logic [63:0] rotr(input logic [63:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (64 - n));
  endfunction

  assign rnd_l = rnd_q;
  assign w2  = w_q[14];
  assign w15 = w_q[1];
  assign s0  = rotr(w15, 1) ^ rotr(w15, 8) ^ (w15 >> 7);
  assign s1  = rotr(w2, 19) ^ rotr(w2, 61) ^ (w2 >> 6);
  assign wn  = s1 + w_q[9] + s0 + w_q[0];
  assign wcur = (rnd_l < 7'd16) ? w_q[0] : wn;
  assign e = v_q[4];
  assign a = v_q[0];
  assign t1 = v_q[7] + (rotr(e, 14) ^ rotr(e, 18) ^ rotr(e, 41))
            + ((e & v_q[5]) ^ (~e & v_q[6])) + sha_pkg::RC[rnd_l] + wcur;
  assign t2 = (rotr(a, 28) ^ rotr(a, 34) ^ rotr(a, 39))
            + ((a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      rnd_q  <= '0;
      wpos_q <= '0;
      cnt_q  <= '0;
      for (int i = 0; i < 8; i++) chain_q[i] <= sha_pkg::IV512[i];
    end else begin
      if (cmd_i.load_iv) begin
        for (int i = 0; i < 8; i++)
          chain_q[i] <= mode_i ? sha_pkg::IV384[i] : sha_pkg::IV512[i];
      end
      if (cmd_i.clr_count) begin
        cnt_q  <= '0;
        wpos_q <= '0;
      end else if (cmd_i.start) begin
        cnt_q <= cnt_q + {60'd0, cmd_i.add_bytes};
      end
      if (cmd_i.push) begin
        wpos_q <= wpos_q + 4'd1;
        if (wpos_q == 4'd15) begin
          busy_q <= 1'b1;
          rnd_q  <= '0;
        end
      end
      if (busy_q) begin
        rnd_q <= rnd_q + 7'd1;
        if (rnd_q == 7'd79) begin
          busy_q <= 1'b0;
          chain_q[0] <= chain_q[0] + t1 + t2;
          chain_q[1] <= chain_q[1] + v_q[0];
          chain_q[2] <= chain_q[2] + v_q[1];
          chain_q[3] <= chain_q[3] + v_q[2];
          chain_q[4] <= chain_q[4] + v_q[3] + t1;
          chain_q[5] <= chain_q[5] + v_q[4];
          chain_q[6] <= chain_q[6] + v_q[5];
          chain_q[7] <= chain_q[7] + v_q[6];
        end
      end
    end
  end

  // w_q is a shift line; w_q[0] is the round word in rounds 0-15
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      buf_q[wpos_q] <= cmd_i.push_word;
    end
    if (cmd_i.push && wpos_q == 4'd15) begin
      for (int i = 0; i < 15; i++) w_q[i] <= buf_q[i];
      w_q[15] <= cmd_i.push_word;
      for (int i = 0; i < 8; i++) v_q[i] <= cmd_i.load_iv ?
        (mode_i ? sha_pkg::IV384[i] : sha_pkg::IV512[i]) : chain_q[i];
    end else if (busy_q) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= wcur;
      v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4]; v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0]; v_q[0] <= t1 + t2;
    end
  end

  assign chain_word_o = chain_q[rd_idx_i];
  assign stat_o.busy = busy_q;
  assign stat_o.wpos = wpos_q;
  assign stat_o.byte_count = cnt_q;

endmodule

// File: design/sha_ctrl.sv
module sha_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              mode_i,
  sha_in_if.sink            in_if,
  sha_out_if.source         out_if,
  input  sha_pkg::stat_t    stat_i,
  input  logic [63:0]       chain_word_i,
  output sha_pkg::cmd_t     cmd_o,
  output logic [2:0]        rd_idx_o
);

  sha_pkg::state_e state_q, state_d;
  logic        started_q, started_d;
  logic [2:0]  idx_q, idx_d;
  logic [1:0]  pend_q, pend_d;   // 0 none, 1 mark word, 2 zero fill
  logic        two_q, two_d;     // second block needed
  logic [3:0]  vb;
  logic [63:0] keep, mark;
  logic [2:0]  last_idx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= sha_pkg::ST_IDLE;
      started_q <= 1'b0;
      idx_q     <= '0;
      pend_q    <= '0;
      two_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      started_q <= started_d;
      idx_q     <= idx_d;
      pend_q    <= pend_d;
      two_q     <= two_d;
    end
  end

  assign vb = (in_if.valid_bytes > 4'd8) ? 4'd8 : in_if.valid_bytes;
  assign keep = (vb == 4'd0) ? 64'd0 : ~(64'hFFFF_FFFF_FFFF_FFFF >> {vb, 3'b000});
  assign mark = {56'd0, sha_pkg::PAD_BYTE} << (7'd56 - {vb[2:0], 3'b000});
  assign last_idx = mode_i ? 3'd5 : 3'd7;
  assign rd_idx_o = idx_q;
  assign out_if.digest_word = chain_word_i;
  assign out_if.word_index = idx_q;
  assign out_if.digest_last = (idx_q == last_idx);

  always_comb begin
    state_d   = state_q;
    started_d = started_q;
    idx_d     = idx_q;
    pend_d    = pend_q;
    two_d     = two_q;
    cmd_o     = '0;
    in_if.ready  = 1'b0;
    out_if.valid = 1'b0;
    unique case (state_q)
      sha_pkg::ST_IDLE: begin
        in_if.ready = 1'b1;
        if (in_if.valid) begin
          cmd_o.load_iv   = !started_q;
          cmd_o.clr_count = 1'b0;
          cmd_o.start     = 1'b1;
          cmd_o.push      = 1'b1;
          started_d       = 1'b1;
          if (!in_if.last_word) begin
            cmd_o.add_bytes = 4'd8;
            cmd_o.push_word = in_if.message_word;
            state_d = (stat_i.wpos == 4'd15) ? sha_pkg::ST_COMP : sha_pkg::ST_IDLE;
          end else begin
            cmd_o.add_bytes = vb;
            if (vb == 4'd8) begin
              cmd_o.push_word = in_if.message_word;
              pend_d = 2'd1;
            end else begin
              cmd_o.push_word = (in_if.message_word & keep) | mark;
              pend_d = 2'd2;
            end
            state_d = sha_pkg::ST_PAD;
          end
          // started_q low: clr_count stays low here; wpos/count were cleared by reset or when the last digest ended
          if (!started_q) begin
            cmd_o.clr_count = 1'b0;
          end
        end
      end
      sha_pkg::ST_COMP: begin
        if (!stat_i.busy) state_d = sha_pkg::ST_IDLE;
      end
      sha_pkg::ST_PAD: begin
        if (!stat_i.busy) begin
          cmd_o.push = 1'b1;
          if (pend_q == 2'd1) begin
            cmd_o.push_word = {sha_pkg::PAD_BYTE, 56'd0};
            pend_d = 2'd2;
            two_d = (stat_i.wpos == 4'd14);
          end else if (two_q || stat_i.wpos < 4'd14) begin
            cmd_o.push_word = '0;
            if (stat_i.wpos == 4'd15) two_d = 1'b0;
          end else if (stat_i.wpos == 4'd14) begin
            cmd_o.push_word = {61'd0, stat_i.byte_count[63:61]};
          end else begin
            cmd_o.push_word = {stat_i.byte_count[60:0], 3'b000};
            idx_d = '0;
            state_d = sha_pkg::ST_OUT;
          end
        end
      end
      sha_pkg::ST_OUT: begin
        if (!stat_i.busy) begin
          out_if.valid = 1'b1;
          if (out_if.ready) begin
            idx_d = idx_q + 3'd1;
            if (idx_q == last_idx) begin
              cmd_o.clr_count = 1'b1;
              started_d = 1'b0;
              idx_d = '0;
              state_d = sha_pkg::ST_IDLE;
            end
          end
        end
      end
      default: state_d = sha_pkg::ST_IDLE;
    endcase
    if (state_q == sha_pkg::ST_PAD && pend_q == 2'd2 && state_d == sha_pkg::ST_PAD &&
        stat_i.busy) begin
      two_d = two_q;
    end
    if (state_q == sha_pkg::ST_IDLE && in_if.valid && in_if.last_word) begin
      two_d = (vb != 4'd8) && (stat_i.wpos == 4'd14);
      if (!started_q) two_d = 1'b0;
    end
  end

endmodule

// File: design/sha512_sha384_hash_top.sv
// channel | dir | payload
// in_if   | in  | message_word[63:0], valid_bytes[3:0], last_word
// out_if  | out | digest_word[63:0], word_index[2:0], digest_last
// cfg     | in  | cfg_we_i / cfg_wdata_i: mode_sha384
// Words are taken one a cycle while idle; the 16th word of a block starts 80
// rounds at one a cycle, and ready stays low until the rounds are done.
// The last word adds one pad word a cycle when not busy, and one or two blocks
// of rounds, then 6 or 8 digest beats. Reset loads SHA-512 values, clears counts.
// Output beats wait on ready without losing place.
module sha512_sha384_hash_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i,
  sha_in_if.sink    in_if,
  sha_out_if.source out_if
);

  logic             mode_q;
  sha_pkg::cmd_t    cmd;
  sha_pkg::stat_t   stat;
  logic [63:0]      chain_word;
  logic [2:0]       rd_idx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) mode_q <= 1'b0;
    else if (cfg_we_i) mode_q <= cfg_wdata_i;
  end

  sha_ctrl u_ctrl (
    .clk_i, .rst_ni, .mode_i(mode_q), .in_if, .out_if,
    .stat_i(stat), .chain_word_i(chain_word), .cmd_o(cmd), .rd_idx_o(rd_idx)
  );

  sha_datapath u_dp (
    .clk_i, .rst_ni, .mode_i(mode_q), .cmd_i(cmd), .rd_idx_i(rd_idx),
    .stat_o(stat), .chain_word_o(chain_word)
  );

endmodule

// File: verif/sha512_sha384_hash_top_tb.sv
`timescale 1ns / 100ps

module sha512_sha384_hash_top_tb;

  typedef struct {
    logic [63:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_beat_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_wdata_i;

  sha_in_if  in_if ();
  sha_out_if out_if ();

  sha512_sha384_hash_top uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_if      (in_if.sink),
    .out_if     (out_if.source)
  );

  localparam int unsigned WATCHDOG_LIMIT = 20000;

  // predictor state
  logic        mode_q;
  logic [63:0] chain_q [8];
  logic [63:0] blk_q [16];
  logic [63:0] nbytes_q;
  int unsigned wpos_q;
  logic        started_q;

  digest_beat_t digest_q[$];
  int unsigned  errors;
  int unsigned  send_idle_pct;
  int unsigned  recv_stall_pct;
  bit           hold_off;
  int unsigned  idle_cycles;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [63:0] rotr(logic [63:0] x, int unsigned n);
    return (x >> n) | (x << (64 - n));
  endfunction

  function automatic void compress_blk();
    logic [63:0] w [16];
    logic [63:0] v [8];
    logic [63:0] wr, t1, t2, s0, s1, w2, w15;
    for (int i = 0; i < 16; i++) w[i] = blk_q[i];
    for (int i = 0; i < 8; i++) v[i] = chain_q[i];
    for (int r = 0; r < 80; r++) begin
      if (r < 16) begin
        wr = w[r];
      end else begin
        w2 = w[(r - 2) & 15];
        w15 = w[(r - 15) & 15];
        s0 = rotr(w15, 1) ^ rotr(w15, 8) ^ (w15 >> 7);
        s1 = rotr(w2, 19) ^ rotr(w2, 61) ^ (w2 >> 6);
        wr = s1 + w[(r - 7) & 15] + s0 + w[r & 15];
        w[r & 15] = wr;
      end
      t1 = v[7] + (rotr(v[4], 14) ^ rotr(v[4], 18) ^ rotr(v[4], 41))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha_pkg::RC[r] + wr;
      t2 = (rotr(v[0], 28) ^ rotr(v[0], 34) ^ rotr(v[0], 39))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain_q[i] = chain_q[i] + v[i];
  endfunction

  function automatic void buffer_word(logic [63:0] w);
    blk_q[wpos_q] = w;
    wpos_q++;
    if (wpos_q >= 16) begin
      compress_blk();
      wpos_q = 0;
    end
  endfunction

  function automatic void predict_digest(logic [63:0] word, logic [3:0] vb_in, logic last);
    int unsigned vb;
    int unsigned cnt;
    logic [63:0] keep;
    digest_beat_t b;
    if (!started_q) begin
      for (int i = 0; i < 8; i++)
        chain_q[i] = mode_q ? sha_pkg::IV384[i] : sha_pkg::IV512[i];
      nbytes_q = '0;
      wpos_q = 0;
      started_q = 1'b1;
    end
    if (!last) begin
      nbytes_q += 8;
      buffer_word(word);
      return;
    end
    vb = (vb_in > 8) ? 8 : vb_in;
    nbytes_q += vb;
    if (vb == 8) begin
      buffer_word(word);
      buffer_word({sha_pkg::PAD_BYTE, 56'h0});
    end else begin
      keep = (vb == 0) ? 64'h0 : ~(64'hFFFF_FFFF_FFFF_FFFF >> (8 * vb));
      buffer_word((word & keep) | (64'({sha_pkg::PAD_BYTE}) << (56 - 8 * vb)));
    end
    if (wpos_q > sha_pkg::LEN_WORD) begin
      while (wpos_q != 0) buffer_word('0);
    end
    while (wpos_q < sha_pkg::LEN_WORD) buffer_word('0);
    buffer_word(nbytes_q >> 61);
    buffer_word(nbytes_q << 3);
    cnt = mode_q ? 6 : 8;
    for (int i = 0; i < cnt; i++) begin
      b.word = chain_q[i];
      b.index = 3'(i);
      b.last = (i + 1 == cnt);
      digest_q.push_back(b);
    end
    started_q = 1'b0;
    nbytes_q = '0;
    wpos_q = 0;
  endfunction

  task automatic send_beat(logic [63:0] word, logic [3:0] vb, logic last);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.message_word <= word;
    in_if.valid_bytes  <= vb;
    in_if.last_word    <= last;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    predict_digest(word, vb, last);
  endtask

  task automatic idle_bus();
    in_if.valid <= 1'b0;
  endtask

  task automatic send_message(int unsigned nwords);
    for (int i = 0; i < nwords; i++) begin
      send_beat({$urandom, $urandom}, 4'($urandom_range(15)), i + 1 == nwords);
    end
  endtask

  task automatic set_mode(logic m);
    idle_bus();
    while (digest_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    mode_q = m;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        if (digest_q.size() == 0) begin
          $display("%0t: unexpected digest beat %h idx %0d", $time,
                   out_if.digest_word, out_if.word_index);
          errors++;
        end else begin
          digest_beat_t e;
          e = digest_q.pop_front();
          if (e.word !== out_if.digest_word || e.index !== out_if.word_index ||
              e.last !== out_if.digest_last) begin
            $display("%0t: digest mismatch exp %h/%0d/%b got %h/%0d/%b", $time,
                     e.word, e.index, e.last, out_if.digest_word,
                     out_if.word_index, out_if.digest_last);
            errors++;
          end
        end
      end
      out_if.ready <= !hold_off &&
                      !(recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("sha512_sha384_hash_top_tb failed");
        $finish;
      end
    end
  end

  task automatic test_directed();
    send_beat(64'h0, 4'd0, 1'b1);                 // empty message
    send_beat(64'h6162_6300_0000_0000, 4'd3, 1'b1);
    send_beat(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b1);
    send_beat(64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 1'b1); // saturates to 8
    send_beat(64'hFFFF_FFFF_FFFF_FFFF, 4'd9, 1'b0);
    send_beat(64'h0123_4567_89AB_CDEF, 4'd7, 1'b1);
    // 13 words + last with 8 bytes: padding spills to a second block
    for (int i = 0; i < 13; i++) send_beat(64'hA5A5_5A5A_0000_FFFF, 4'd1, 1'b0);
    send_beat(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b1);
  endtask

  task automatic test_block_edges();
    int unsigned lens[5] = '{14, 15, 16, 17, 1};
    foreach (lens[i]) send_message(lens[i]);
  endtask

  task automatic test_mode_switch();
    send_beat(64'h1, 4'd8, 1'b0);
    idle_bus();
    cfg_we_i    <= 1'b1;  // mid-message: digest length follows, IV stays
    cfg_wdata_i <= ~mode_q;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    mode_q = ~mode_q;
    send_beat(64'h2, 4'd4, 1'b1);
  endtask

  task automatic test_random(int unsigned nitems);
    int unsigned sent;
    int unsigned n;
    sent = 0;
    while (sent < nitems) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(17, 34) : $urandom_range(1, 6);
      send_message(n);
      sent += n;
    end
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (400) @(posedge clk_i);
        hold_off = 1'b0;
      end
      begin
        send_message(3);
        send_message(2);
        send_message(12);
      end
    join
  endtask

  initial begin
    errors = 0;
    idle_cycles = 0;
    hold_off = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = 1'b0;
    in_if.valid = 1'b0;
    in_if.message_word = '0;
    in_if.valid_bytes = '0;
    in_if.last_word = 1'b0;
    out_if.ready = 1'b0;
    mode_q = 1'b0;
    started_q = 1'b0;
    nbytes_q = '0;
    wpos_q = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    set_mode(1'b1);
    test_directed();
    test_block_edges();
    set_mode(1'b0);
    test_block_edges();
    test_mode_switch();
    set_mode(1'b0);
    test_random(6);
    send_idle_pct = 57;
    set_mode(1'b1);
    test_random(6);
    send_idle_pct = 0;
    recv_stall_pct = 57;
    test_random(6);
    send_idle_pct = 36;
    recv_stall_pct = 36;
    set_mode(1'b0);
    test_random(6);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_backpressure();

    idle_bus();
    while (digest_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (errors == 0) begin
      $display("sha512_sha384_hash_top_tb passed");
    end else begin
      $display("sha512_sha384_hash_top_tb failed");
    end
    $finish;
  end

endmodule

// File: sim.f
design/sha_pkg.sv
design/sha_if.sv
design/sha_datapath.sv
design/sha_ctrl.sv
design/sha512_sha384_hash_top.sv
verif/sha512_sha384_hash_top_tb.sv
